FILE: design/mi4_pkg.sv
// Shared types and constants of the 4x4 fixed-point matrix inverse.
// Holds the sequencer state codes, the divider result bundle and the minor tables.
// No dependencies.
package mi4_pkg;

	localparam int ELEM_W = 32;
	// A signed 3x3 cofactor of 32-bit elements fits in 97 bits, the determinant in 130.
	localparam int COF_W  = 97;
	localparam int DET_W  = 130;
	localparam int CHUNKS = 4;
	localparam int CW_W   = CHUNKS * ELEM_W;
	// Quotient bits produced by the divider; anything wider saturates.
	localparam int QBITS  = 33;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_C_A,
		ST_C_B,
		ST_C_C,
		ST_C_D,
		ST_C_E,
		ST_C_F,
		ST_C_W,
		ST_D_A,
		ST_D_B,
		ST_D_M,
		ST_D_ACC,
		ST_D_FIN,
		ST_O_RD,
		ST_O_NUM,
		ST_O_START,
		ST_O_WAIT,
		ST_O_SHOW
	} mi4_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_CHECK,
		DV_ITER,
		DV_DONE
	} mi4_div_state_t;

	typedef struct packed {
		logic        done;
		logic        ovf;
		logic [31:0] value;
	} mi4_div_res_t;

	// Column permutation of each of the six terms of a 3x3 determinant,
	// packed {p2, p1, p0}, and a mask of the terms that are subtracted.
	localparam logic [5:0] PERM [6] = '{
		{2'd2, 2'd1, 2'd0},
		{2'd1, 2'd2, 2'd0},
		{2'd2, 2'd0, 2'd1},
		{2'd0, 2'd2, 2'd1},
		{2'd1, 2'd0, 2'd2},
		{2'd0, 2'd1, 2'd2}
	};
	localparam logic [5:0] PSIGN = 6'b100110;

	// Maps a minor row or column to the full matrix, skipping the excluded one.
	function automatic logic [1:0] skip(input logic [1:0] k, input logic [1:0] excl);
		logic [1:0] r;
		r = (k < excl) ? k : k + 2'd1;
		return r;
	endfunction

endpackage

FILE: design/mi4_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the matrix store and the cofactor store. No dependencies.
module mi4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/mi4_div.sv
// Bit-serial restoring divider with saturation to a signed 32-bit result.
// One quotient bit per cycle after a single overflow check. Depends on mi4_pkg.
module mi4_div #(
	parameter int NUM_W = 148,
	parameter int DEN_W = 131
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NUM_W-1:0]   num,
	input  logic [DEN_W-1:0]   den,
	input  logic               neg,
	output mi4_pkg::mi4_div_res_t res
);

	localparam int QB    = mi4_pkg::QBITS;
	localparam int CW    = (NUM_W > DEN_W + 1) ? NUM_W : DEN_W + 1;
	localparam int CNT_W = $clog2(QB);

	mi4_pkg::mi4_div_state_t state_q, state_d;

	logic [CW-1:0]    rem_q;
	logic [QB-1:0]    low_q;
	logic [QB-1:0]    quo_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic             big_q;
	logic [CNT_W-1:0] cnt_q;

	logic [CW-1:0] den_ext;
	logic [CW-1:0] trial;
	logic          fits;
	logic          sat;

	assign den_ext = CW'(den_q);
	assign trial   = {rem_q[CW-2:0], low_q[QB-1]};
	assign fits    = (trial >= den_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mi4_pkg::DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mi4_pkg::DV_IDLE: begin
				if (start) begin
					state_d = mi4_pkg::DV_CHECK;
				end
			end
			mi4_pkg::DV_CHECK: begin
				state_d = (rem_q >= den_ext) ? mi4_pkg::DV_DONE : mi4_pkg::DV_ITER;
			end
			mi4_pkg::DV_ITER: begin
				if (cnt_q == CNT_W'(QB - 1)) begin
					state_d = mi4_pkg::DV_DONE;
				end
			end
			mi4_pkg::DV_DONE: begin
				state_d = mi4_pkg::DV_IDLE;
			end
			default: begin
				state_d = mi4_pkg::DV_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mi4_pkg::DV_IDLE: begin
				if (start) begin
					// The high part must stay below the divisor, else the quotient
					// needs more than QB bits.
					rem_q <= CW'(num) >> QB;
					low_q <= num[QB-1:0];
					den_q <= den;
					neg_q <= neg;
					quo_q <= '0;
					cnt_q <= '0;
				end
			end
			mi4_pkg::DV_CHECK: begin
				big_q <= (rem_q >= den_ext);
			end
			mi4_pkg::DV_ITER: begin
				rem_q <= fits ? trial - den_ext : trial;
				quo_q <= {quo_q[QB-2:0], fits};
				low_q <= {low_q[QB-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (neg_q) begin
			sat = big_q || quo_q[32] || (quo_q[31] && (|quo_q[30:0]));
		end else begin
			sat = big_q || quo_q[32] || quo_q[31];
		end
		res.done = (state_q == mi4_pkg::DV_DONE);
		res.ovf  = sat;
		if (sat) begin
			res.value = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			res.value = neg_q ? (~quo_q[31:0] + 32'd1) : quo_q[31:0];
		end
	end

endmodule

FILE: design/matrix_inverse_4x4.sv
// 4x4 fixed-point matrix inverse by cofactors and adjugate.
// Top level: sequencer, shared 33x32 multiplier, wide accumulator.
// Depends on mi4_pkg, mi4_ram and mi4_div.
//
// Usage: send the 16 elements of a column-major matrix, signed Q(31-F).F,
// one request each on the s_axis channel. After the sixteenth the block
// computes the 16 signed cofactors into a cofactor memory, then the
// determinant along row 0, and sends the 16 inverse elements in column-major
// order on the m_axis channel with tlast on the last. tuser carries the
// singular flag (zero determinant, value 0) and the per-element saturation flag.
// Loading accepts an element whenever s_axis_tvalid is high. Each cofactor
// is six triple products (three reads and three multiplies each) and one
// write. Each output element then goes through the bit-serial divider (one
// quotient bit per cycle, 33 bits, after the overflow check) unless the
// matrix is singular. No new matrix can start before the last result of
// the previous one is taken: s_axis is held not ready from the
// sixteenth element until the last result is taken. A stalled receiver holds
// the current result in the output register. Reset returns the block to loading
// at slot 0; the memories need no clearing since every entry is written before it is read.
module matrix_inverse_4x4 #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] elem_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] out_value, [35:32] out_index, [39:36] zero
	output logic        m_axis_tlast,
	output logic [1:0]  m_axis_tuser   // [0] singular, [1] overflow
);

	localparam int COF_W = mi4_pkg::COF_W;
	localparam int DET_W = mi4_pkg::DET_W;
	localparam int SHL_W = COF_W + 2 * FRAC_BITS + 1;
	localparam int NUM_W = ((SHL_W > DET_W) ? SHL_W : DET_W) + 1;
	localparam int DEN_W = DET_W + 1;

	mi4_pkg::mi4_state_t state_q, state_d;

	logic [3:0] load_pos_q;
	logic [3:0] cof_idx_q;
	logic [2:0] term_q;
	logic [1:0] chunk_q;

	logic [31:0]                a_q, c_q, phi_q, e_q;
	logic [mi4_pkg::CW_W-1:0]   cw_q;
	logic signed [64:0]         mul_q;
	logic [DET_W-1:0]           acc_q;
	logic [DET_W-1:0]           absd_q;
	logic                       dsign_q;
	logic                       sing_q;
	logic [NUM_W-1:0]           num_q;
	logic                       nneg_q;
	logic [31:0]                out_value_q;
	logic                       ovf_q;

	logic [3:0]        m_raddr;
	logic [31:0]       m_rdata;
	logic [COF_W-1:0]  c_rdata;
	logic [COF_W-1:0]  cof_wdata;
	logic              cof_we;
	logic              in_acc;

	logic signed [32:0] mx;
	logic signed [31:0] my;
	logic [DET_W-1:0]   mul_ext;
	logic [DET_W-1:0]   add_x;
	logic               add_en;
	logic               add_sub;
	logic [1:0]         elem_k;
	logic [1:0]         row_i, col_j;
	logic [5:0]         perm_w;
	logic [COF_W-1:0]   absn;
	logic [31:0]        chunk;
	logic               div_start;
	mi4_pkg::mi4_div_res_t div_res;

	assign row_i  = cof_idx_q[3:2];
	assign col_j  = cof_idx_q[1:0];
	assign perm_w = mi4_pkg::PERM[term_q];
	assign in_acc = s_axis_tvalid && s_axis_tready;

	mi4_ram #(.WIDTH(32), .DEPTH(16)) u_mat (
		.clk   (clk),
		.we    (in_acc),
		.waddr (load_pos_q),
		.wdata (s_axis_tdata),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	mi4_ram #(.WIDTH(COF_W), .DEPTH(16)) u_cof (
		.clk   (clk),
		.we    (cof_we),
		.waddr (cof_idx_q),
		.wdata (cof_wdata),
		.raddr (cof_idx_q),
		.rdata (c_rdata)
	);

	mi4_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    ({absd_q, 1'b0}),
		.neg    (nneg_q),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mi4_pkg::ST_LOAD;
			load_pos_q <= '0;
			cof_idx_q  <= '0;
			term_q     <= '0;
			chunk_q    <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				load_pos_q <= load_pos_q + 4'd1;
			end
			case (state_q)
				mi4_pkg::ST_C_F: begin
					term_q <= (term_q == 3'd5) ? 3'd0 : term_q + 3'd1;
				end
				mi4_pkg::ST_C_W: begin
					cof_idx_q <= cof_idx_q + 4'd1;
				end
				mi4_pkg::ST_D_B: begin
					chunk_q <= '0;
				end
				mi4_pkg::ST_D_ACC: begin
					chunk_q <= chunk_q + 2'd1;
					if (chunk_q == 2'd3) begin
						cof_idx_q <= (cof_idx_q[1:0] == 2'd3) ? 4'd0 : cof_idx_q + 4'd1;
					end
				end
				mi4_pkg::ST_O_SHOW: begin
					if (m_axis_tready) begin
						cof_idx_q <= cof_idx_q + 4'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		div_start     = 1'b0;
		cof_we        = 1'b0;
		case (state_q)
			mi4_pkg::ST_LOAD: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && load_pos_q == 4'd15) begin
					state_d = mi4_pkg::ST_C_A;
				end
			end
			mi4_pkg::ST_C_A: state_d = mi4_pkg::ST_C_B;
			mi4_pkg::ST_C_B: state_d = mi4_pkg::ST_C_C;
			mi4_pkg::ST_C_C: state_d = mi4_pkg::ST_C_D;
			mi4_pkg::ST_C_D: state_d = mi4_pkg::ST_C_E;
			mi4_pkg::ST_C_E: state_d = mi4_pkg::ST_C_F;
			mi4_pkg::ST_C_F: begin
				state_d = (term_q == 3'd5) ? mi4_pkg::ST_C_W : mi4_pkg::ST_C_A;
			end
			mi4_pkg::ST_C_W: begin
				cof_we  = 1'b1;
				state_d = (cof_idx_q == 4'd15) ? mi4_pkg::ST_D_A : mi4_pkg::ST_C_A;
			end
			mi4_pkg::ST_D_A: state_d = mi4_pkg::ST_D_B;
			mi4_pkg::ST_D_B: state_d = mi4_pkg::ST_D_M;
			mi4_pkg::ST_D_M: state_d = mi4_pkg::ST_D_ACC;
			mi4_pkg::ST_D_ACC: begin
				if (chunk_q != 2'd3) begin
					state_d = mi4_pkg::ST_D_M;
				end else if (cof_idx_q[1:0] == 2'd3) begin
					state_d = mi4_pkg::ST_D_FIN;
				end else begin
					state_d = mi4_pkg::ST_D_A;
				end
			end
			mi4_pkg::ST_D_FIN: state_d = mi4_pkg::ST_O_RD;
			mi4_pkg::ST_O_RD:  state_d = mi4_pkg::ST_O_NUM;
			mi4_pkg::ST_O_NUM: begin
				state_d = sing_q ? mi4_pkg::ST_O_SHOW : mi4_pkg::ST_O_START;
			end
			mi4_pkg::ST_O_START: begin
				div_start = 1'b1;
				state_d   = mi4_pkg::ST_O_WAIT;
			end
			mi4_pkg::ST_O_WAIT: begin
				if (div_res.done) begin
					state_d = mi4_pkg::ST_O_SHOW;
				end
			end
			mi4_pkg::ST_O_SHOW: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready) begin
					state_d = (cof_idx_q == 4'd15) ? mi4_pkg::ST_LOAD : mi4_pkg::ST_O_RD;
				end
			end
			default: begin
				state_d = mi4_pkg::ST_LOAD;
			end
		endcase
	end

	// Read address of the matrix store, operands of the shared multiplier and accumulator control.
	always_comb begin
		case (state_q)
			mi4_pkg::ST_C_B: elem_k = 2'd1;
			mi4_pkg::ST_C_C: elem_k = 2'd2;
			default:         elem_k = 2'd0;
		endcase
		case (state_q)
			mi4_pkg::ST_C_A, mi4_pkg::ST_C_B, mi4_pkg::ST_C_C: begin
				m_raddr = {mi4_pkg::skip(perm_w[2*elem_k +: 2], col_j),
					mi4_pkg::skip(elem_k, row_i)};
			end
			mi4_pkg::ST_D_A: m_raddr = {cof_idx_q[1:0], 2'b00};
			default:         m_raddr = 4'd0;
		endcase

		chunk = cw_q[{chunk_q, 5'd0} +: 32];
		mx = '0;
		my = '0;
		case (state_q)
			mi4_pkg::ST_C_C: begin
				mx = {a_q[31], a_q};
				my = m_rdata;
			end
			mi4_pkg::ST_C_D: begin
				// Low half of the pair product is unsigned, the high half signed.
				mx = {1'b0, mul_q[31:0]};
				my = m_rdata;
			end
			mi4_pkg::ST_C_E: begin
				mx = {phi_q[31], phi_q};
				my = c_q;
			end
			mi4_pkg::ST_D_M: begin
				mx = (chunk_q == 2'd3) ? {chunk[31], chunk} : {1'b0, chunk};
				my = e_q;
			end
			default: begin
			end
		endcase

		mul_ext = {{(DET_W - 65){mul_q[64]}}, mul_q};
		add_en  = 1'b0;
		add_sub = 1'b0;
		add_x   = mul_ext;
		case (state_q)
			mi4_pkg::ST_C_E: begin
				add_en  = 1'b1;
				add_sub = mi4_pkg::PSIGN[term_q];
			end
			mi4_pkg::ST_C_F: begin
				add_en  = 1'b1;
				add_sub = mi4_pkg::PSIGN[term_q];
				add_x   = mul_ext << 32;
			end
			mi4_pkg::ST_D_ACC: begin
				add_en = 1'b1;
				add_x  = mul_ext << {chunk_q, 5'd0};
			end
			default: begin
			end
		endcase

		cof_wdata = (row_i[0] ^ col_j[0]) ? COF_W'(~acc_q + 1'b1) : acc_q[COF_W-1:0];
		absn      = c_rdata[COF_W-1] ? (~c_rdata + 1'b1) : c_rdata;
	end

	always_ff @(posedge clk) begin
		mul_q <= mx * my;
		if (add_en) begin
			acc_q <= add_sub ? acc_q - add_x : acc_q + add_x;
		end
		case (state_q)
			mi4_pkg::ST_LOAD: begin
				acc_q <= '0;
			end
			mi4_pkg::ST_C_B: begin
				a_q <= m_rdata;
			end
			mi4_pkg::ST_C_D: begin
				c_q   <= m_rdata;
				phi_q <= mul_q[63:32];
			end
			mi4_pkg::ST_C_W: begin
				acc_q <= '0;
			end
			mi4_pkg::ST_D_B: begin
				e_q  <= m_rdata;
				cw_q <= {{(mi4_pkg::CW_W - COF_W){c_rdata[COF_W-1]}}, c_rdata};
			end
			mi4_pkg::ST_D_FIN: begin
				sing_q  <= (acc_q == '0);
				dsign_q <= acc_q[DET_W-1];
				absd_q  <= acc_q[DET_W-1] ? (~acc_q + 1'b1) : acc_q;
			end
			mi4_pkg::ST_O_NUM: begin
				num_q  <= (NUM_W'(absn) << (2 * FRAC_BITS + 1)) + NUM_W'(absd_q);
				nneg_q <= c_rdata[COF_W-1] ^ dsign_q;
				if (sing_q) begin
					out_value_q <= '0;
					ovf_q       <= 1'b0;
				end
			end
			mi4_pkg::ST_O_WAIT: begin
				if (div_res.done) begin
					out_value_q <= div_res.value;
					ovf_q       <= div_res.ovf;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tdata = {4'd0, cof_idx_q, out_value_q};
	assign m_axis_tlast = (cof_idx_q == 4'd15);
	assign m_axis_tuser = {ovf_q, sing_q};

endmodule

FILE: tb/matrix_inverse_4x4_tb.sv
// Self-checking testbench for the 4x4 fixed-point matrix inverse.
// Streams matrices in, predicts every inverse element with exact wide arithmetic.
// Depends on matrix_inverse_4x4.
module matrix_inverse_4x4_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 1500;
	localparam int RANDOM_MATRICES = 14;

	typedef enum int {MX_FULL, MX_WELL, MX_SING, MX_TINY, MX_ZERO} mx_kind_t;

	typedef struct {
		logic [31:0] value;
		logic [3:0]  index;
		logic        last;
		logic        singular;
		logic        overflow;
	} inv_elem_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [1:0]  m_axis_tuser;

	matrix_inverse_4x4 #(.FRAC_BITS(FRAC)) dut (.*);

	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	logic [31:0] loaded [16];
	logic [3:0]  load_slot;
	inv_elem_t   inverse_q [$];
	int          errors;
	int          idle_cycles;
	int          cycle_count;
	int          results_seen;
	bit          hold_out;

	// Directed matrix: diagonal extremes, off-diagonal zero, column-major.
	logic [31:0] directed_rows [16] = '{
		32'h0001_0000, 32'h0, 32'h0, 32'h0,
		32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0,
		32'h0, 32'h0, 32'h8000_0000, 32'h0,
		32'h0, 32'h0, 32'h0, 32'h0000_0001
	};

	// Its inverse is the reciprocal diagonal; the entry of smallest magnitude saturates.
	logic [31:0] directed_expect [16] = '{
		32'h0001_0000, 32'h0, 32'h0, 32'h0,
		32'h0, 32'h0000_0002, 32'h0, 32'h0,
		32'h0, 32'h0, 32'hFFFF_FFFE, 32'h0,
		32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF
	};

	function automatic logic signed [199:0] elem_at(int r, int c);
		logic signed [199:0] x;
		x = $signed(loaded[c * 4 + r]);
		return x;
	endfunction

	function automatic logic signed [199:0] cofactor_of(int i, int j);
		int rs [3];
		int cs [3];
		int a, b;
		logic signed [199:0] m [3][3];
		logic signed [199:0] d;
		a = 0;
		b = 0;
		for (int k = 0; k < 4; k++) begin
			if (k != i) begin rs[a] = k; a++; end
			if (k != j) begin cs[b] = k; b++; end
		end
		for (int p = 0; p < 3; p++)
			for (int q = 0; q < 3; q++)
				m[p][q] = elem_at(rs[p], cs[q]);
		d = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
		  - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
		  + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
		return ((i + j) % 2) ? -d : d;
	endfunction

	// Inverse = adjugate / determinant, rounded half away from zero, saturated.
	task automatic predict_inverse();
		logic signed [199:0] cof [4][4];
		logic signed [199:0] det;
		logic [199:0] an, ad, quo;
		inv_elem_t e;
		bit neg;
		det = '0;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				cof[i][j] = cofactor_of(i, j);
		for (int j = 0; j < 4; j++)
			det = det + elem_at(0, j) * cof[0][j];
		ad = det[199] ? -det : det;
		for (int k = 0; k < 16; k++) begin
			e.index = k[3:0];
			e.last = (k == 15);
			e.singular = (det == 0);
			e.overflow = 1'b0;
			e.value = '0;
			if (det != 0) begin
				an = cof[k / 4][k % 4][199] ? -cof[k / 4][k % 4] : cof[k / 4][k % 4];
				neg = cof[k / 4][k % 4][199] ^ det[199];
				quo = ((an << (2 * FRAC + 1)) + ad) / (ad << 1);
				if (!neg) begin
					if (quo > 200'h7FFF_FFFF) begin
						e.value = 32'h7FFF_FFFF; e.overflow = 1'b1;
					end else e.value = quo[31:0];
				end else begin
					if (quo > 200'h8000_0000) begin
						e.value = 32'h8000_0000; e.overflow = 1'b1;
					end else e.value = -quo[31:0];
				end
			end
			inverse_q.push_back(e);
		end
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
		errors++;
	endtask

	// Load tracking, result checking and the watchdog.
	always @(posedge clk) begin
		inv_elem_t e;
		if (arst_n) begin
			cycle_count++;
			idle_cycles++;
			if (s_axis_tvalid && s_axis_tready) begin
				idle_cycles = 0;
				loaded[load_slot] = s_axis_tdata;
				if (load_slot == 4'd15) predict_inverse();
				load_slot = load_slot + 4'd1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				idle_cycles = 0;
				if (inverse_q.size() == 0)
					report("unexpected result", m_axis_tdata[31:0], 32'd0);
				else begin
					e = inverse_q.pop_front();
					if (results_seen < 16) begin
						e.value = directed_expect[results_seen];
						e.overflow = (results_seen == 15);
					end
					results_seen++;
					if (m_axis_tdata[31:0] !== e.value) report("value", m_axis_tdata[31:0], e.value);
					if (m_axis_tdata[39:32] !== {4'd0, e.index})
						report("index", 32'(m_axis_tdata[39:32]), 32'(e.index));
					if (m_axis_tlast !== e.last)
						report("last", 32'(m_axis_tlast), 32'(e.last));
					if (m_axis_tuser[0] !== e.singular)
						report("singular", 32'(m_axis_tuser[0]), 32'(e.singular));
					if (m_axis_tuser[1] !== e.overflow)
						report("overflow", 32'(m_axis_tuser[1]), 32'(e.overflow));
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no request accepted for %0d cycles", IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Receiver: random stalls, one long hold-off, and a window with no stalls.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_out) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out = 0;
			end
			if (cycle_count > 8000 && cycle_count < 12000) m_axis_tready <= 1'b1;
			else m_axis_tready <= ($urandom_range(99) >= 12);
		end
	end

	task automatic send_elem(logic [31:0] v, int item_no);
		if (!(item_no > 100 && item_no < 150) && $urandom_range(99) < 12) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	function automatic logic [31:0] small_signed(int mag);
		int v;
		v = $urandom_range(2 * mag) - mag;
		return v;
	endfunction

	initial begin
		logic [31:0] mx [16];
		mx_kind_t kind;
		int items;
		errors = 0;
		items = 0;
		load_slot = 4'd0;
		cycle_count = 0;
		idle_cycles = 0;
		results_seen = 0;
		hold_out = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < 16; r++) begin
			send_elem(directed_rows[r], items);
			items++;
		end

		for (int n = 0; n < RANDOM_MATRICES; n++) begin
			case (n)
				0: kind = MX_ZERO;
				1: kind = MX_TINY;
				2: kind = MX_SING;
				3: kind = MX_FULL;
				default: kind = mx_kind_t'($urandom_range(3));
			endcase
			if (kind == MX_FULL && $urandom_range(1)) kind = MX_WELL;
			for (int k = 0; k < 16; k++) begin
				case (kind)
					MX_FULL: mx[k] = $urandom;
					MX_ZERO: mx[k] = '0;
					MX_TINY: mx[k] = (k % 5 == 0) ? small_signed(3) : 32'h0;
					default: mx[k] = (k % 5 == 0)
						? (small_signed(32'h3_0000) | 32'h1_0000) : small_signed(32'h8000);
				endcase
			end
			if (kind == MX_SING)
				for (int r = 0; r < 4; r++) mx[8 + r] = mx[r];
			if (n == 5) hold_out = 1;
			for (int k = 0; k < 16; k++) begin
				send_elem(mx[k], items);
				items++;
			end
			// Let one matrix drain completely before the next.
			if (n == 8) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (inverse_q.size() != 0) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (inverse_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
